// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LXSFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define LXSFR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/lxsfr_pkg.sv =====
// ---------------------------------------------------------------------------
// lxsfr_pkg
// Types and constants shared by the length/XOR/status frame receiver.
// ---------------------------------------------------------------------------
package lxsfr_pkg;

    // Reset value of the payload capacity register.
    localparam logic [15:0] CAPACITY_RESET = 16'd32;

    // Status bytes that carry meaning.
    localparam logic [7:0] STATUS_OK_HI   = 8'h90;
    localparam logic [7:0] STATUS_OK_LO   = 8'h00;
    localparam logic [7:0] STATUS_HINT_HI = 8'h6C;

    // Smallest legal frame length: the two status bytes alone.
    localparam logic [15:0] MIN_LENGTH = 16'd2;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Result data packing: 51 field bits padded to 7 bytes.
    localparam int RESULT_BITS = 51;
    localparam int TDATA_W     = 56;
    localparam int TDATA_PAD_W = TDATA_W - RESULT_BITS;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_XOR_BAD  = 3'd1,
        VERDICT_HINT     = 3'd2,
        VERDICT_OTHER    = 3'd3,
        VERDICT_SHORT    = 3'd4
    } verdict_t;

    // One received byte and its start flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_item_t;

    // One result word.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] stored_count;
        verdict_t    verdict;
        logic [7:0]  hint_length;
        logic [15:0] status_word;
        logic        frame_done;
    } result_t;

endpackage

// ===== src/lxsfr_in_stage.sv =====
// ---------------------------------------------------------------------------
// lxsfr_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ---------------------------------------------------------------------------
module lxsfr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lxsfr_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output lxsfr_pkg::in_item_t out_item
);

    logic                valid_reg;
    lxsfr_pkg::in_item_t item_reg;

    // The register frees up whenever its word is consumed in the same cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/lxsfr_parser.sv =====
// ---------------------------------------------------------------------------
// lxsfr_parser
// Frame parser: per-byte state update and result formation in the same cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lxsfr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  lxsfr_pkg::in_item_t in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output lxsfr_pkg::result_t  res
);

    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_SW1,
        PH_SW2,
        PH_XOR
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] stored_total_reg, stored_total_next;
    logic [7:0]  status_first_reg, status_first_next;
    logic [7:0]  status_second_reg, status_second_next;
    logic [15:0] capacity_reg;
    logic [15:0] frame_len;
    logic [7:0]  b;
    logic        step;
    logic        has_res;

    // A byte is consumed whenever the result stage can take a word.
    assign in_ready = res_ready;
    assign step     = in_valid && res_ready;
    assign res_valid = step && has_res;

    assign b         = in_item.rx_byte;
    assign frame_len = {length_high_reg, b};
    assign phase_eff = in_item.frame_start ? PH_LEN_HI : phase_reg;

    // Next state and result for the byte at the head of the input register.
    always_comb
    begin
        phase_next         = phase_reg;
        length_high_next   = length_high_reg;
        bytes_left_next    = bytes_left_reg;
        xor_next           = xor_reg;
        stored_total_next  = stored_total_reg;
        status_first_next  = status_first_reg;
        status_second_next = status_second_reg;
        has_res            = 1'b0;
        res                = '0;

        unique case (phase_eff)
            PH_LEN_HI:
            begin
                length_high_next   = b;
                xor_next           = b;
                stored_total_next  = '0;
                status_first_next  = '0;
                status_second_next = '0;
                bytes_left_next    = '0;
                phase_next         = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                xor_next = xor_reg ^ b;
                if (frame_len < lxsfr_pkg::MIN_LENGTH)
                begin
                    // Lengths of zero or one cannot even hold the status word.
                    phase_next       = PH_LEN_HI;
                    has_res          = 1'b1;
                    res.kind         = lxsfr_pkg::KIND_VERDICT;
                    res.verdict      = lxsfr_pkg::VERDICT_SHORT;
                    res.frame_done   = 1'b1;
                end
                else
                begin
                    bytes_left_next = frame_len - lxsfr_pkg::MIN_LENGTH;
                    phase_next = (frame_len == lxsfr_pkg::MIN_LENGTH) ? PH_SW1 : PH_DATA;
                end
            end
            PH_DATA:
            begin
                xor_next = xor_reg ^ b;
                // Bytes past the capacity still count into the checksum.
                if (stored_total_reg < capacity_reg)
                begin
                    stored_total_next = stored_total_reg + 16'd1;
                    has_res           = 1'b1;
                    res.kind          = lxsfr_pkg::KIND_PAYLOAD;
                    res.payload_byte  = b;
                    res.stored_count  = stored_total_reg + 16'd1;
                end
                bytes_left_next = bytes_left_reg - 16'd1;
                if (bytes_left_reg == 16'd1)
                begin
                    phase_next = PH_SW1;
                end
            end
            PH_SW1:
            begin
                status_first_next = b;
                xor_next          = xor_reg ^ b;
                phase_next        = PH_SW2;
            end
            PH_SW2:
            begin
                status_second_next = b;
                xor_next           = xor_reg ^ b;
                phase_next         = PH_XOR;
            end
            PH_XOR:
            begin
                phase_next       = PH_LEN_HI;
                has_res          = 1'b1;
                res.kind         = lxsfr_pkg::KIND_VERDICT;
                res.stored_count = stored_total_reg;
                res.status_word  = {status_first_reg, status_second_reg};
                res.frame_done   = 1'b1;
                // The checksum check takes precedence over the status word.
                priority if (xor_reg != b)
                begin
                    res.verdict = lxsfr_pkg::VERDICT_XOR_BAD;
                end
                else if (status_first_reg == lxsfr_pkg::STATUS_OK_HI &&
                         status_second_reg == lxsfr_pkg::STATUS_OK_LO)
                begin
                    res.verdict = lxsfr_pkg::VERDICT_OK;
                end
                else if (status_first_reg == lxsfr_pkg::STATUS_HINT_HI)
                begin
                    res.verdict     = lxsfr_pkg::VERDICT_HINT;
                    res.hint_length = status_second_reg;
                end
                else
                begin
                    res.verdict = lxsfr_pkg::VERDICT_OTHER;
                end
            end
            default:
            begin
                phase_next = PH_LEN_HI;
            end
        endcase
    end

    // Parser state and capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEN_HI;
            length_high_reg   <= '0;
            bytes_left_reg    <= '0;
            xor_reg           <= '0;
            stored_total_reg  <= '0;
            status_first_reg  <= '0;
            status_second_reg <= '0;
            capacity_reg      <= lxsfr_pkg::CAPACITY_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (step)
            begin
                phase_reg         <= phase_next;
                length_high_reg   <= length_high_next;
                bytes_left_reg    <= bytes_left_next;
                xor_reg           <= xor_next;
                stored_total_reg  <= stored_total_next;
                status_first_reg  <= status_first_next;
                status_second_reg <= status_second_next;
            end
        end
    end

    // A verdict always returns the parser to waiting for a length.
    `LXSFR_ASSERT(a_verdict_idles, (res_valid && res.frame_done) |=> (phase_reg == PH_LEN_HI), "parser not idle after verdict")
    // Each emitted payload byte advances the stored count by one.
    `LXSFR_ASSERT(a_payload_counts, (res_valid && (res.kind == lxsfr_pkg::KIND_PAYLOAD)) |=> (stored_total_reg == $past(stored_total_reg) + 16'd1), "stored count did not advance")
    // The data phase is never entered with nothing left to read.
    `LXSFR_ASSERT_NEVER(a_data_nonempty, (phase_reg == PH_DATA) && (bytes_left_reg == 16'd0), "data phase with zero bytes left")

endmodule

// ===== src/lxsfr_out_skid.sv =====
// ---------------------------------------------------------------------------
// lxsfr_out_skid
// Result register with a skid entry, so the ready toward the parser is a flop.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lxsfr_out_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lxsfr_pkg::result_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lxsfr_pkg::result_t out_data
);

    logic               main_valid_reg;
    logic               skid_valid_reg;
    lxsfr_pkg::result_t main_reg;
    lxsfr_pkg::result_t skid_reg;
    logic               main_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign main_free = !main_valid_reg || out_ready;

    // Valid flags: the skid entry drains into the main register first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_reg <= in_data;
        end
    end

    // The skid entry is only ever filled behind a held main word.
    `LXSFR_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid entry valid with empty main register")
    // A stalled skid entry is neither lost nor altered.
    `LXSFR_ASSERT(a_skid_holds, (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_reg)), "stalled skid entry changed")

endmodule

// ===== src/length_xor_status_frame_receiver_top.sv =====
// ---------------------------------------------------------------------------
// length_xor_status_frame_receiver_top
// Receiver for length-prefixed frames with XOR checksum and status word.
// ---------------------------------------------------------------------------
// Usage: frame bytes enter on the s_ stream, one word per byte; s_tuser set
// marks the first length byte and restarts the parser. Each payload byte
// within the configured capacity leaves as one m_ word with m_tuser low;
// the XOR byte ends the frame with a verdict word (m_tuser and m_tlast high).
// A length of zero or one yields a verdict at the second length byte.
// cfg_we/cfg_wdata write the payload capacity, which resets to 32.
// A result leaves through the input register, then the result register.
// Throughput: one byte per cycle while the result side is not stalled, with
// the combinational parser between the input and result registers.
// Reset clears the parser to await a length byte and empties both stages.
// When the receiver stalls, up to two results wait in the result register
// and its skid entry; the input keeps taking bytes until both are full and
// the input register is occupied, then s_tready drops.
// ---------------------------------------------------------------------------
module length_xor_status_frame_receiver_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [15:0]                  cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  logic                         s_tuser,   // [0] frame_start
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] payload_byte, [23:8] stored_count, [26:24] verdict,
    // [34:27] hint_length, [50:35] status_word, [55:51] zero
    output logic [lxsfr_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tuser,   // [0] kind
    output logic                         m_tlast    // frame_done
);

    lxsfr_pkg::in_item_t s_item;
    lxsfr_pkg::in_item_t p_item;
    lxsfr_pkg::result_t  p_res;
    lxsfr_pkg::result_t  m_res;
    logic                p_valid;
    logic                p_ready;
    logic                r_valid;
    logic                r_ready;

    assign s_item.rx_byte     = s_tdata;
    assign s_item.frame_start = s_tuser;

    // Input register.
    lxsfr_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_item  (p_item)
    );

    // Frame parser.
    lxsfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .in_item   (p_item),
        .res_valid (r_valid),
        .res_ready (r_ready),
        .res       (p_res)
    );

    // Result register with skid entry.
    lxsfr_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_data   (p_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    // Pack the result fields onto the master stream.
    assign m_tdata = {{lxsfr_pkg::TDATA_PAD_W{1'b0}},
                      m_res.status_word,
                      m_res.hint_length,
                      m_res.verdict,
                      m_res.stored_count,
                      m_res.payload_byte};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.frame_done;

endmodule

// ===== tb/frame_receiver_checker.sv =====
// ---------------------------------------------------------------------------
// frame_receiver_checker
// Watches both streams of the frame receiver, tracks the frame parser in
// step with every accepted byte, and compares each result word with the
// oldest predicted one, field by field.
// ---------------------------------------------------------------------------
module frame_receiver_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lxsfr_pkg::TDATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        WAIT_LEN_HI,
        WAIT_LEN_LO,
        IN_PAYLOAD,
        WAIT_STATUS_HI,
        WAIT_STATUS_LO,
        WAIT_CHECK
    } parse_phase_t;

    // Parser state as the block should hold it.
    parse_phase_t phase;
    logic [7:0]   len_high;
    logic [15:0]  bytes_left;
    logic [7:0]   xor_acc;
    logic [15:0]  stored_total;
    logic [7:0]   status_hi;
    logic [7:0]   status_lo;
    logic [15:0]  capacity;

    // Result words predicted but not yet seen on the output.
    lxsfr_pkg::result_t expected_results[$];

    // Advance the parser by one received byte and queue the word it yields.
    function automatic void parse_byte(input logic [7:0] b, input logic start);
        lxsfr_pkg::result_t r;
        logic [15:0]        frame_len;
        r = '0;
        if (start)
            phase = WAIT_LEN_HI;
        case (phase)
            WAIT_LEN_HI:
            begin
                len_high     = b;
                xor_acc      = b;
                stored_total = '0;
                status_hi    = '0;
                status_lo    = '0;
                bytes_left   = '0;
                phase        = WAIT_LEN_LO;
            end
            WAIT_LEN_LO:
            begin
                frame_len = {len_high, b};
                xor_acc  ^= b;
                if (frame_len < lxsfr_pkg::MIN_LENGTH)
                begin
                    // Lengths of zero or one end the frame at once.
                    phase        = WAIT_LEN_HI;
                    r.kind       = lxsfr_pkg::KIND_VERDICT;
                    r.verdict    = lxsfr_pkg::VERDICT_SHORT;
                    r.frame_done = 1'b1;
                    expected_results.push_back(r);
                end
                else
                begin
                    bytes_left = frame_len - lxsfr_pkg::MIN_LENGTH;
                    phase      = (bytes_left == 16'd0) ? WAIT_STATUS_HI : IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                xor_acc ^= b;
                // Bytes past the capacity only feed the checksum.
                if (stored_total < capacity)
                begin
                    stored_total   = stored_total + 16'd1;
                    r.kind         = lxsfr_pkg::KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.stored_count = stored_total;
                    expected_results.push_back(r);
                end
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                    phase = WAIT_STATUS_HI;
            end
            WAIT_STATUS_HI:
            begin
                status_hi = b;
                xor_acc  ^= b;
                phase     = WAIT_STATUS_LO;
            end
            WAIT_STATUS_LO:
            begin
                status_lo = b;
                xor_acc  ^= b;
                phase     = WAIT_CHECK;
            end
            default:
            begin
                // A bad checksum wins over whatever the status word says.
                r.kind         = lxsfr_pkg::KIND_VERDICT;
                r.stored_count = stored_total;
                r.status_word  = {status_hi, status_lo};
                r.frame_done   = 1'b1;
                if (xor_acc != b)
                    r.verdict = lxsfr_pkg::VERDICT_XOR_BAD;
                else if (status_hi == lxsfr_pkg::STATUS_OK_HI &&
                         status_lo == lxsfr_pkg::STATUS_OK_LO)
                    r.verdict = lxsfr_pkg::VERDICT_OK;
                else if (status_hi == lxsfr_pkg::STATUS_HINT_HI)
                begin
                    r.verdict     = lxsfr_pkg::VERDICT_HINT;
                    r.hint_length = status_lo;
                end
                else
                    r.verdict = lxsfr_pkg::VERDICT_OTHER;
                phase = WAIT_LEN_HI;
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // Report one field that differs from its prediction.
    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Unpack the output word and hold it against the oldest prediction.
    function automatic void check_result();
        lxsfr_pkg::result_t want;
        lxsfr_pkg::result_t got;
        got.kind         = m_tuser;
        got.payload_byte = m_tdata[7:0];
        got.stored_count = m_tdata[23:8];
        got.verdict      = lxsfr_pkg::verdict_t'(m_tdata[26:24]);
        got.hint_length  = m_tdata[34:27];
        got.status_word  = m_tdata[50:35];
        got.frame_done   = m_tlast;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual %h (user %b, last %b)",
                     $time, m_tdata, m_tuser, m_tlast);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", 16'(want.kind), 16'(got.kind));
        compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
        compare_field("stored_count", want.stored_count, got.stored_count);
        compare_field("verdict", 16'(want.verdict), 16'(got.verdict));
        compare_field("hint_length", 16'(want.hint_length), 16'(got.hint_length));
        compare_field("status_word", want.status_word, got.status_word);
        compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        compare_field("padding", 16'd0,
                      16'(m_tdata[lxsfr_pkg::TDATA_W-1:lxsfr_pkg::RESULT_BITS]));
    endfunction

    // Outputs are checked before the new byte is parsed: a result never
    // leaves in the cycle its byte is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase        = WAIT_LEN_HI;
            len_high     = '0;
            bytes_left   = '0;
            xor_acc      = '0;
            stored_total = '0;
            status_hi    = '0;
            status_lo    = '0;
            capacity     = lxsfr_pkg::CAPACITY_RESET;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser);
            if (cfg_we)
                capacity = cfg_wdata;
        end
        results_pending = expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the length/XOR/status frame receiver: directed frames for the
// short, ok, hint and bad-checksum verdicts and parser corners, then random frames, truncated frames and
// loose bytes under several payload capacities, with random gaps and
// stalls on both streams and one long output stall.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 150;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [15:0]                    cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [lxsfr_pkg::TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    int          mismatch_count;
    int          results_pending;
    int          bytes_sent;
    int unsigned cycle_count;
    bit          idle_on;
    bit          hold_req;

    length_xor_status_frame_receiver_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    frame_receiver_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall before each word, plus one long hold-off
    // on request while the byte side keeps offering.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Offer one byte after a random gap and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = start;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Build a frame with random payload and send it, or only its first
    // cut bytes when cut is not negative.
    task automatic send_frame(input logic [15:0] frame_len, input logic [15:0] status,
                              input bit bad_xor, input logic first_start, input int cut);
        logic [7:0] frame_bytes[$];
        logic [7:0] xor_sum;
        int         count;
        frame_bytes.push_back(frame_len[15:8]);
        frame_bytes.push_back(frame_len[7:0]);
        if (frame_len >= lxsfr_pkg::MIN_LENGTH)
        begin
            repeat (frame_len - lxsfr_pkg::MIN_LENGTH) frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(status[15:8]);
            frame_bytes.push_back(status[7:0]);
            xor_sum = '0;
            foreach (frame_bytes[i])
                xor_sum ^= frame_bytes[i];
            if (bad_xor)
                xor_sum ^= 8'($urandom_range(1, 255));
            frame_bytes.push_back(xor_sum);
        end
        count = (cut < 0) ? frame_bytes.size() : cut;
        for (int i = 0; i < count && i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], (i == 0) ? first_start : 1'b0);
    endtask

    // Mostly short frames, some beyond the usual capacities, a few too short.
    function automatic logic [15:0] random_length();
        case ($urandom_range(0, 19))
            0:       return 16'($urandom_range(0, 1));
            1:       return lxsfr_pkg::MIN_LENGTH;
            2:       return 16'($urandom_range(41, 90));
            default: return 16'($urandom_range(3, 40));
        endcase
    endfunction

    function automatic logic [15:0] random_status();
        case ($urandom_range(0, 5))
            0, 1:    return {lxsfr_pkg::STATUS_OK_HI, lxsfr_pkg::STATUS_OK_LO};
            2:       return {lxsfr_pkg::STATUS_HINT_HI, 8'($urandom)};
            3:       return {lxsfr_pkg::STATUS_OK_HI, 8'($urandom_range(1, 255))};
            default: return 16'($urandom);
        endcase
    endfunction

    // Random traffic: whole frames, abandoned frames and loose bytes.
    task automatic random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_frame(random_length(), random_status(), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 3) != 0, -1);
            else if (pick < 88)
                send_frame(random_length(), random_status(), 1'b0, 1'b1,
                           $urandom_range(1, 8));
            else
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    // Let every predicted word arrive and the pipeline empty out.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [15:0] capacities[6];
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        capacities = '{16'd0, 16'hFFFF, 16'd1, 16'd5, 16'($urandom_range(2, 40)), 16'd32};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames under the reset capacity.
        // Zero length, first byte taken while idle without a start flag.
        send_frame(16'd0, 16'h0000, 1'b0, 1'b0, -1);
        // Length one gives the short-length verdict.
        send_frame(16'd1, 16'h0000, 1'b0, 1'b1, -1);
        // Empty payload straight to an ok status.
        send_frame(lxsfr_pkg::MIN_LENGTH, {lxsfr_pkg::STATUS_OK_HI, lxsfr_pkg::STATUS_OK_LO},
                   1'b0, 1'b1, -1);
        // Length hint with the largest hint value.
        send_frame(lxsfr_pkg::MIN_LENGTH, {lxsfr_pkg::STATUS_HINT_HI, 8'hFF}, 1'b0, 1'b1, -1);
        // A frame dropped after three bytes by a restart, whose checksum
        // is wrong although the status says ok.
        send_frame(16'd5, 16'h6A82, 1'b0, 1'b1, 3);
        send_frame(lxsfr_pkg::MIN_LENGTH, {lxsfr_pkg::STATUS_OK_HI, lxsfr_pkg::STATUS_OK_LO},
                   1'b1, 1'b1, -1);
        wait_drained();

        // Random phases, one capacity each; odd phases run without gaps.
        foreach (capacities[p])
        begin
            write_capacity(capacities[p]);
            idle_on = (p % 2 == 0);
            if (capacities[p] == 16'hFFFF)
            begin
                // Stall the result side through a frame far longer than
                // the block can buffer, so it fills up and holds off input.
                hold_req = 1'b1;
                send_frame(16'd42, {lxsfr_pkg::STATUS_OK_HI, lxsfr_pkg::STATUS_OK_LO},
                           1'b0, 1'b1, -1);
            end
            random_traffic(PHASE_BYTES);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/lxsfr_pkg.sv
src/lxsfr_in_stage.sv
src/lxsfr_parser.sv
src/lxsfr_out_skid.sv
src/length_xor_status_frame_receiver_top.sv
tb/frame_receiver_checker.sv
tb/tb_top.sv
